// ----- rtl/pdagl_pkg.sv -----
// shared constants and types for the pcm to dac gain limiter
package pdagl_pkg;

    // fixed field widths
    localparam int unsigned PCM_W        = 16;
    localparam int unsigned GAIN_W       = 6;
    localparam int unsigned DAC_BITS_DEF = 12;

    // gain after reset, in tenths
    localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd18;

    // copy count held as copies minus one
    localparam int unsigned LEFT_W = 2;

    // sample modes, the last one gives no result
    typedef enum logic [1:0] {
        MODE_STEREO = 2'd0,
        MODE_DUP2   = 2'd1,
        MODE_DUP4   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

endpackage

// ----- rtl/pdagl_channels.sv -----
// valid/ready channel interfaces for pcm input items and dac result items
interface pdagl_pcm_if;
    import pdagl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PCM_W-1:0]  pcm_sample;
    logic [1:0]               mode;

    modport source (output valid, output pcm_sample, output mode, input ready);
    modport sink   (input valid, input pcm_sample, input mode, output ready);
endinterface

interface pdagl_dac_if #(
    parameter int unsigned DAC_BITS = pdagl_pkg::DAC_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [DAC_BITS-1:0]  dac_code;
    logic                 clipped;
    logic                 last_copy;

    modport source (output valid, output dac_code, output clipped, output last_copy,
                    input ready);
    modport sink   (input valid, input dac_code, input clipped, input last_copy,
                    output ready);
endinterface

// ----- rtl/pcm_to_dac_auto_gain_limiter.sv -----
// pcm to dac converter with running gain limiter, three register stages
// the first result of an item is shown from the output register, after the item has passed
// the input and stage two registers; one item per cycle in stereo mode while the output port
//   is ready, while in the duplicating modes it sends each copy in its own cycle and holds new items back
// the gain multiply, clamp and gain decrement are all worked out in stage two
// reset (async, active low) empties all stages and loads the gain with 18 tenths
module pcm_to_dac_auto_gain_limiter #(
    parameter int unsigned DAC_BITS = pdagl_pkg::DAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pdagl_pkg::GAIN_W-1:0] cfg_wdata,
    pdagl_pcm_if.sink                   pcm_in,
    pdagl_dac_if.source                 dac_out
);
    import pdagl_pkg::*;

    // derived widths and constants
    localparam int unsigned MW   = PCM_W + DAC_BITS - 1;   // |sample| * scale
    localparam int unsigned RN   = MW + 4;                 // reciprocal shift
    localparam int unsigned RW   = MW + 1;                 // reciprocal width
    localparam int unsigned MQW  = MW - 3;                 // quotient by ten
    localparam int unsigned XW   = MQW + GAIN_W + 1;       // scaled sum
    localparam int unsigned QW   = XW - 16;                // after / 65536
    localparam int unsigned VW   = DAC_BITS + 5;           // signed code
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << RN) + 64'd9) / 64'd10);
    localparam logic [DAC_BITS-1:0] SCALE   = DAC_BITS'((1 << (DAC_BITS - 1)) - 1);
    localparam logic [DAC_BITS-1:0] DAC_MAX = DAC_BITS'((1 << DAC_BITS) - 1);

    // stage one: input register
    logic                    s1_valid_reg;
    logic signed [PCM_W-1:0] s1_pcm_reg;
    mode_t                   s1_mode_reg;

    // stage two: split magnitude, gain loop
    logic                    s2_valid_reg;
    logic [MQW-1:0]          s2_mq_reg;
    logic [3:0]              s2_mr_reg;
    logic                    s2_neg_reg;
    mode_t                   s2_mode_reg;

    // output register
    logic                    out_valid_reg;
    logic [DAC_BITS-1:0]     out_code_reg;
    logic                    out_clip_reg;
    logic [LEFT_W-1:0]       out_left_reg;

    // gain state
    logic [GAIN_W-1:0]       gain_reg;
    logic [GAIN_W-1:0]       gain_next;

    // handshake control
    logic in_fire;
    logic out_fire;
    logic out_free;
    logic s1_go;
    logic s2_go;

    assign out_fire = out_valid_reg & dac_out.ready;
    assign out_free = ~out_valid_reg | (out_fire & (out_left_reg == '0));
    assign s2_go    = s2_valid_reg & out_free;
    assign s1_go    = s1_valid_reg & (~s2_valid_reg | out_free);
    assign pcm_in.ready = ~s1_valid_reg | ~s2_valid_reg | out_free;
    assign in_fire  = pcm_in.valid & pcm_in.ready;

    // stage one math: magnitude times scale, then split by ten
    logic                 s1_neg;
    logic [PCM_W-1:0]     s1_mag;
    logic [MW-1:0]        s1_m;
    logic [MW+RW-1:0]     s1_prod;
    logic [MQW-1:0]       s1_mq;
    logic [MW-1:0]        s1_mq10;
    logic [3:0]           s1_mr;

    always_comb
    begin
        s1_neg  = s1_pcm_reg[PCM_W-1];
        s1_mag  = s1_neg ? (~s1_pcm_reg + 1'b1) : s1_pcm_reg;
        s1_m    = (MW'(s1_mag) << (DAC_BITS - 1)) - MW'(s1_mag);
        s1_prod = (MW+RW)'(s1_m) * (MW+RW)'(RECIP);
        s1_mq   = s1_prod[RN +: MQW];
        s1_mq10 = (MW'(s1_mq) << 3) + (MW'(s1_mq) << 1);
        s1_mr   = 4'(s1_m - s1_mq10);
    end

    // stage two math: gain product, divide, offset and clamp
    logic [9:0]               s2_rg;
    logic [17:0]              s2_rg_scaled;
    logic [GAIN_W-1:0]        s2_u;
    logic [XW-1:0]            s2_x;
    logic [QW-1:0]            s2_q;
    logic [VW-1:0]            s2_qx;
    logic signed [VW-1:0]     s2_term;
    logic signed [VW-1:0]     s2_v;
    logic [DAC_BITS-1:0]      s2_offset;
    logic [LEFT_W-1:0]        s2_left;
    logic                     s2_clip_hi;
    logic                     s2_clip_lo;
    logic                     s2_clip;
    logic [DAC_BITS-1:0]      s2_code;

    always_comb
    begin
        case (s2_mode_reg)
            MODE_STEREO:
            begin
                s2_offset = SCALE;
                s2_left   = LEFT_W'(0);
            end
            MODE_DUP2:
            begin
                s2_offset = SCALE + 1'b1;
                s2_left   = LEFT_W'(1);
            end
            MODE_DUP4:
            begin
                s2_offset = SCALE + 1'b1;
                s2_left   = LEFT_W'(3);
            end
            default:
            begin
                s2_offset = SCALE;
                s2_left   = LEFT_W'(0);
            end
        endcase
    end

    always_comb
    begin
        // remainder share: floor(mr * gain / 10) by reciprocal 205 / 2048
        s2_rg        = 10'(s2_mr_reg) * 10'(gain_reg);
        s2_rg_scaled = 18'(s2_rg) * 18'd205;
        s2_u         = GAIN_W'(s2_rg_scaled >> 11);
        s2_x         = XW'(s2_mq_reg) * XW'(gain_reg) + XW'(s2_u);
        s2_q         = s2_x[XW-1:16];
        s2_qx        = VW'(s2_q);
        s2_term      = s2_neg_reg ? -$signed(s2_qx) : $signed(s2_qx);
        s2_v         = $signed(VW'(s2_offset)) + s2_term;
        s2_clip_hi   = s2_v > $signed(VW'(DAC_MAX));
        s2_clip_lo   = s2_v < $signed(VW'(0));
        s2_clip      = s2_clip_hi | s2_clip_lo;
        if (s2_clip_hi)
        begin
            s2_code = DAC_MAX;
        end
        else if (s2_clip_lo)
        begin
            s2_code = '0;
        end
        else
        begin
            s2_code = s2_v[DAC_BITS-1:0];
        end
    end

    // running gain: load on write, else one tenth down per clamped item, never below zero
    always_comb
    begin
        gain_next = gain_reg;
        if (cfg_we)
        begin
            gain_next = cfg_wdata;
        end
        else if (s2_go && s2_clip && (gain_reg != '0))
        begin
            gain_next = gain_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
            gain_reg      <= GAIN_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            if (in_fire)
            begin
                // the unused mode drops here and gives no result
                s1_valid_reg <= (pcm_in.mode != MODE_UNUSED);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
                out_left_reg  <= s2_left;
            end
            else if (out_fire)
            begin
                if (out_left_reg == '0)
                begin
                    out_valid_reg <= 1'b0;
                end
                else
                begin
                    out_left_reg <= out_left_reg - 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pcm_reg  <= pcm_in.pcm_sample;
            s1_mode_reg <= mode_t'(pcm_in.mode);
        end
        if (s1_go)
        begin
            s2_mq_reg   <= s1_mq;
            s2_mr_reg   <= s1_mr;
            s2_neg_reg  <= s1_neg;
            s2_mode_reg <= s1_mode_reg;
        end
        if (s2_go)
        begin
            out_code_reg <= s2_code;
            out_clip_reg <= s2_clip;
        end
    end

    // output port
    assign dac_out.valid     = out_valid_reg;
    assign dac_out.dac_code  = out_code_reg;
    assign dac_out.clipped   = out_clip_reg;
    assign dac_out.last_copy = (out_left_reg == '0);

endmodule
